>>> src/adim_pkg.sv
// ----------------------------------------------------------------------------
// Double integrator package
// Types, constants and register indexes shared by the integrator files.
// ----------------------------------------------------------------------------
package adim_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACCUM_BITS_DEF  = 48;

  localparam logic [15:0] TIME_STEP_RST = 16'd2621;
  localparam logic [15:0] SKIP_RST      = 16'd80;
  localparam logic [11:0] GAIN_ACC_RST  = 12'd1280;
  localparam logic [11:0] GAIN_VEL_RST  = 12'd256;
  localparam logic [11:0] GAIN_DIST_RST = 12'd256;

  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP = 8'd0,
    REG_SKIP      = 8'd1,
    REG_GAIN_ACC  = 8'd2,
    REG_GAIN_VEL  = 8'd3,
    REG_GAIN_DIST = 8'd4
  } adim_reg_t;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_VEL     = 8'b0000_0010,
    S_DMUL    = 8'b0000_0100,
    S_DADD    = 8'b0000_1000,
    S_SQ      = 8'b0001_0000,
    S_ROOT_GO = 8'b0010_0000,
    S_ROOT    = 8'b0100_0000,
    S_SCALE   = 8'b1000_0000
  } adim_state_t;

  typedef struct packed {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic               record_start;
  } adim_in_t;

  typedef struct packed {
    logic        [31:0] mag_acc;
    logic        [31:0] mag_vel;
    logic        [31:0] mag_dist;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] dist_x;
    logic signed [31:0] dist_y;
    logic signed [31:0] dist_z;
  } adim_out_t;

  // Per-lane step strobes from the sequencer.
  typedef struct packed {
    logic load;   // take a new sample
    logic clear;  // record start: zero the integrators and previous sample
    logic prime;  // priming sample: only store it as the previous sample
    logic vel;
    logic dmul;
    logic dadd;
    logic sq;
  } adim_lane_ctrl_t;

endpackage

>>> src/adim_sqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Restoring digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
module adim_sqrt #(
  parameter int IN_W = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [IN_W-1:0]      radicand,
  output logic                 busy,
  output logic [IN_W/2-1:0]    root
);

  localparam int H   = IN_W / 2;
  localparam int CNT_W = $clog2(H + 1);

  logic [IN_W-1:0]  rad_r;
  logic [H+2:0]     rem_r;
  logic [H-1:0]     root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [H+2:0] rem_sh;
  logic [H+2:0] trial;
  logic         fits;

  assign rem_sh = {rem_r[H:0], rad_r[IN_W-1:IN_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(H);
    end else if (busy_r) begin
      busy_r <= (cnt_r != CNT_W'(1));
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[IN_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[H-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

>>> src/adim_lane.sv
// ----------------------------------------------------------------------------
// Axis integrator lane
// Trapezoidal acceleration-to-velocity-to-displacement integration of one axis.
// ----------------------------------------------------------------------------
module adim_lane
  import adim_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACCUM_BITS  = ACCUM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  adim_lane_ctrl_t               ctrl,
  input  logic signed [SAMPLE_BITS-1:0] smp,
  input  logic [15:0]                   dt,
  output logic [2*SAMPLE_BITS-1:0]      sq_acc,
  output logic [63:0]                   sq_vel,
  output logic [63:0]                   sq_dist,
  output logic signed [31:0]            vel_o,
  output logic signed [31:0]            dist_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int AB = ACCUM_BITS;
  localparam int SW = AB + SB + 18;

  logic signed [SB-1:0]  cur_r, prev_r;
  logic signed [AB-1:0]  vel_r, vold_r, dist_r;
  logic signed [AB:0]    phi_r;
  logic [31:0]           plo_r;
  logic [2*SB-1:0]       sq_acc_r;
  logic [63:0]           sq_vel_r, sq_dist_r;

  logic signed [SB:0]    s;
  logic signed [16:0]    sdt;
  logic signed [SB+17:0] vp;
  logic signed [SW-1:0]  vsum, dsum, dinc;
  logic signed [AB:0]    hs;
  logic signed [AB-17:0] hh;
  logic [15:0]           hl;
  logic signed [AB-1:0]  vel_nxt, dist_nxt;

  function automatic logic signed [AB-1:0] sat_acc(input logic signed [SW-1:0] x);
    logic [SW-AB:0] top;
    top = x[SW-1:AB-1];
    if ((&top) || !(|top)) return x[AB-1:0];
    return x[SW-1] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AB-1:0] x);
    logic [AB-32:0] top;
    top = x[AB-1:31];
    if ((&top) || !(|top)) return x[31:0];
    return x[AB-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // Velocity step: the sum of the two samples times dt, halved by an arithmetic shift that drops the low bit.
  assign s    = $signed({prev_r[SB-1], prev_r}) + $signed({cur_r[SB-1], cur_r});
  assign sdt  = $signed({1'b0, dt});
  assign vp   = s * sdt;
  assign vsum = $signed({{(AB+SB+18-AB){vel_r[AB-1]}}, vel_r})
              + ($signed({{(SW-SB-18){vp[SB+17]}}, vp}) >>> 1);
  assign vel_nxt = sat_acc(vsum);

  // Displacement step: the half sum is split so that each product stays narrow.
  assign hs = $signed({vold_r[AB-1], vold_r}) + $signed({vel_r[AB-1], vel_r});
  assign hh = hs[AB:17];
  assign hl = hs[16:1];
  assign dinc = $signed({{(SW-AB-1){phi_r[AB]}}, phi_r})
              + $signed({{(SW-16){1'b0}}, plo_r[31:16]});
  assign dsum = $signed({{(SW-AB){dist_r[AB-1]}}, dist_r}) + dinc;
  assign dist_nxt = sat_acc(dsum);

  assign vel_o  = sat32(vel_r);
  assign dist_o = sat32(dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      vel_r  <= '0;
      dist_r <= '0;
    end else begin
      if (ctrl.load) begin
        if (ctrl.clear) begin
          vel_r  <= '0;
          dist_r <= '0;
        end
        if (ctrl.prime) prev_r <= smp;
        else if (ctrl.clear) prev_r <= '0;
      end
      if (ctrl.vel) begin
        prev_r <= cur_r;
        vel_r  <= vel_nxt;
      end
      if (ctrl.dadd) dist_r <= dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) cur_r <= smp;
    if (ctrl.vel) vold_r <= vel_r;
    if (ctrl.dmul) begin
      phi_r <= hh * sdt;
      plo_r <= hl * dt;
    end
    if (ctrl.sq) begin
      sq_acc_r  <= (2*SB)'(cur_r) * (2*SB)'(cur_r);
      sq_vel_r  <= 64'(vel_o) * 64'(vel_o);
      sq_dist_r <= 64'(dist_o) * 64'(dist_o);
    end
  end

  assign sq_acc  = sq_acc_r;
  assign sq_vel  = sq_vel_r;
  assign sq_dist = sq_dist_r;

endmodule

>>> src/accel_double_integrator_magnitude_core.sv
// ----------------------------------------------------------------------------
// Three-axis double integrator with magnitude outputs
// Integrates acceleration to velocity and displacement per axis and reports
// gain-scaled magnitudes of all three quantities.
// ----------------------------------------------------------------------------
// Sequence: a word that yields a result passes the VEL, DMUL, DADD, SQ,
// ROOT_GO, ROOT and SCALE states; the longest root, max(32, SAMPLE_BITS + 9)
// bits, sets the throughput. A priming word keeps the block idle. The next
// word is taken while a result waits in the output register.
// Reset (rst_n, synchronous, active low) zeroes the integrators, the sample
// count and the output valid, and restores the register defaults.
// ----------------------------------------------------------------------------
module accel_double_integrator_magnitude_core
  import adim_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACCUM_BITS  = ACCUM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  adim_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output adim_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int ACC_W = 2 * SB + 18;   // acceleration radicand, sum of squares in Q.16

  // Configuration registers. The user issues writes only while the block is idle; the block does not enforce it.
  logic [15:0] time_step_r, skip_r;
  logic [11:0] gain_acc_r, gain_vel_r, gain_dist_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RST;
      skip_r      <= SKIP_RST;
      gain_acc_r  <= GAIN_ACC_RST;
      gain_vel_r  <= GAIN_VEL_RST;
      gain_dist_r <= GAIN_DIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIME_STEP: time_step_r <= cfg_data;
        REG_SKIP:      skip_r      <= cfg_data;
        REG_GAIN_ACC:  gain_acc_r  <= cfg_data[11:0];
        REG_GAIN_VEL:  gain_vel_r  <= cfg_data[11:0];
        REG_GAIN_DIST: gain_dist_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Sequencer. A word is only taken in the idle state; the sample count decides
  // whether it primes the previous-sample registers or runs the integrators.
  adim_state_t state_r, state_nxt;
  logic [15:0] idx_r, idx_nxt, idx_eff;
  logic        in_acc, run, root_busy, out_load;
  adim_lane_ctrl_t ctrl;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign idx_eff  = in_data.record_start ? 16'd0 : idx_r;
  assign run      = (idx_eff >= skip_r);

  assign ctrl.load  = in_acc;
  assign ctrl.clear = in_data.record_start;
  assign ctrl.prime = !run;
  assign ctrl.vel   = (state_r == S_VEL);
  assign ctrl.dmul  = (state_r == S_DMUL);
  assign ctrl.dadd  = (state_r == S_DADD);
  assign ctrl.sq    = (state_r == S_SQ);

  // The result register frees up either when empty or when its word is taken.
  assign out_load = (state_r == S_SCALE) && (!out_valid || !out_stall);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    if (in_acc) idx_nxt = (idx_eff == 16'hffff) ? idx_eff : idx_eff + 16'd1;
    case (state_r)
      S_IDLE:    if (in_acc && run) state_nxt = S_VEL;
      S_VEL:     state_nxt = S_DMUL;
      S_DMUL:    state_nxt = S_DADD;
      S_DADD:    state_nxt = S_SQ;
      S_SQ:      state_nxt = S_ROOT_GO;
      S_ROOT_GO: state_nxt = S_ROOT;
      S_ROOT:    if (!root_busy) state_nxt = S_SCALE;
      S_SCALE:   if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Sample extraction: the low SAMPLE_BITS of each field, zero-extended if wider.
  logic [SB+15:0]       ext_x, ext_y, ext_z;
  logic signed [SB-1:0] smp_x, smp_y, smp_z;
  assign ext_x = {{SB{1'b0}}, in_data.acc_x};
  assign ext_y = {{SB{1'b0}}, in_data.acc_y};
  assign ext_z = {{SB{1'b0}}, in_data.acc_z};
  assign smp_x = ext_x[SB-1:0];
  assign smp_y = ext_y[SB-1:0];
  assign smp_z = ext_z[SB-1:0];

  // Three axis lanes run in lock step.
  logic [2*SB-1:0]    sqa_x, sqa_y, sqa_z;
  logic [63:0]        sqv_x, sqv_y, sqv_z, sqd_x, sqd_y, sqd_z;
  logic signed [31:0] vx, vy, vz, dx, dy, dz;

  adim_lane #(.SAMPLE_BITS(SAMPLE_BITS), .ACCUM_BITS(ACCUM_BITS)) u_lane_x (
    .clk, .rst_n, .ctrl, .smp(smp_x), .dt(time_step_r),
    .sq_acc(sqa_x), .sq_vel(sqv_x), .sq_dist(sqd_x), .vel_o(vx), .dist_o(dx));
  adim_lane #(.SAMPLE_BITS(SAMPLE_BITS), .ACCUM_BITS(ACCUM_BITS)) u_lane_y (
    .clk, .rst_n, .ctrl, .smp(smp_y), .dt(time_step_r),
    .sq_acc(sqa_y), .sq_vel(sqv_y), .sq_dist(sqd_y), .vel_o(vy), .dist_o(dy));
  adim_lane #(.SAMPLE_BITS(SAMPLE_BITS), .ACCUM_BITS(ACCUM_BITS)) u_lane_z (
    .clk, .rst_n, .ctrl, .smp(smp_z), .dt(time_step_r),
    .sq_acc(sqa_z), .sq_vel(sqv_z), .sq_dist(sqd_z), .vel_o(vz), .dist_o(dz));

  // Merge: sum the lanes' squares and take the three roots side by side.
  // Three squares of at most 2^62 each cannot overflow 64 bits.
  logic [2*SB+1:0]   sum_acc;
  logic [ACC_W-1:0]  rad_acc;
  logic [63:0]       rad_vel, rad_dist;
  logic [SB+8:0]     root_acc;
  logic [31:0]       root_vel, root_dist;
  logic              busy_a, busy_v, busy_d, root_go;

  assign sum_acc  = {2'b00, sqa_x} + {2'b00, sqa_y} + {2'b00, sqa_z};
  assign rad_acc  = {sum_acc, 16'h0000};
  assign rad_vel  = sqv_x + sqv_y + sqv_z;
  assign rad_dist = sqd_x + sqd_y + sqd_z;
  assign root_go  = (state_r == S_ROOT_GO);
  assign root_busy = busy_a || busy_v || busy_d;

  adim_sqrt #(.IN_W(ACC_W)) u_sqrt_acc (
    .clk, .rst_n, .start(root_go), .radicand(rad_acc), .busy(busy_a), .root(root_acc));
  adim_sqrt #(.IN_W(64)) u_sqrt_vel (
    .clk, .rst_n, .start(root_go), .radicand(rad_vel), .busy(busy_v), .root(root_vel));
  adim_sqrt #(.IN_W(64)) u_sqrt_dist (
    .clk, .rst_n, .start(root_go), .radicand(rad_dist), .busy(busy_d), .root(root_dist));

  // Gain scaling with saturation to 32 bits.
  logic [SB+20:0] prod_acc;
  logic [43:0]    prod_vel, prod_dist;
  logic [63:0]    sh_acc, sh_vel, sh_dist;

  assign prod_acc  = root_acc * gain_acc_r;
  assign prod_vel  = root_vel * gain_vel_r;
  assign prod_dist = root_dist * gain_dist_r;
  assign sh_acc    = 64'(prod_acc >> 16);
  assign sh_vel    = 64'(prod_vel >> 24);
  assign sh_dist   = 64'(prod_dist >> 24);

  // Output register.
  adim_out_t out_r;
  logic      out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.mag_acc  <= (|sh_acc[63:32])  ? 32'hffff_ffff : sh_acc[31:0];
      out_r.mag_vel  <= (|sh_vel[63:32])  ? 32'hffff_ffff : sh_vel[31:0];
      out_r.mag_dist <= (|sh_dist[63:32]) ? 32'hffff_ffff : sh_dist[31:0];
      out_r.vel_x    <= vx;
      out_r.vel_y    <= vy;
      out_r.vel_z    <= vz;
      out_r.dist_x   <= dx;
      out_r.dist_y   <= dy;
      out_r.dist_z   <= dz;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on the sequencing.
  a_no_accept_while_root: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !root_busy)
    else $error("word accepted while the root units are busy");

  a_result_from_scale: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_SCALE))
    else $error("result raised outside the scaling step");

  a_root_started: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT_GO) |=> root_busy)
    else $error("root units did not start");

  a_index_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_data.record_start) |=> (idx_r >= $past(idx_r)))
    else $error("sample count went backwards without a record start");

endmodule
